// ===== hdl/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

	localparam logic [7:0] CH_PAD = 8'h3D;

	// One mapped character: ok clear for a byte outside the alphabet
	typedef struct packed {
		logic       ok;
		logic       pad;
		logic [5:0] val;
	} sym_t;

	// Result set handed from the decoder to the output register
	typedef struct packed {
		logic [1:0]      cnt;
		kind_t           kind;
		logic [2:0][7:0] bytes;
	} res_t;

	function automatic logic is_space(input logic [7:0] ch);
		return ((ch >= 8'h09) && (ch <= 8'h0D)) || (ch == 8'h20);
	endfunction

	function automatic sym_t map_symbol(input logic [7:0] ch);
		sym_t       s;
		logic [7:0] t;
		s = '0;
		t = '0;
		priority if ((ch >= 8'h41) && (ch <= 8'h5A)) begin
			t = ch - 8'd65;
			s.ok = 1'b1;
		end else if ((ch >= 8'h61) && (ch <= 8'h7A)) begin
			t = ch - 8'd71;
			s.ok = 1'b1;
		end else if ((ch >= 8'h30) && (ch <= 8'h39)) begin
			t = ch + 8'd4;
			s.ok = 1'b1;
		end else if (ch == 8'h2B) begin
			t = 8'd62;
			s.ok = 1'b1;
		end else if (ch == 8'h2F) begin
			t = 8'd63;
			s.ok = 1'b1;
		end else if (ch == CH_PAD) begin
			s.ok  = 1'b1;
			s.pad = 1'b1;
		end else begin
			s.ok = 1'b0;
		end
		s.val = t[5:0];
		return s;
	endfunction

endpackage

// ===== hdl/b64d_decode.sv =====
`timescale 1ns / 1ps

module b64d_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ena,
	input  logic [7:0]     ch,
	input  logic           eot,
	output b64d_pkg::res_t res
);

	b64d_pkg::sym_t       grp_q [3];
	logic [1:0]           cnt_q;
	logic                 failed_q;

	b64d_pkg::sym_t       sym;
	logic                 skip;
	logic                 complete;
	logic                 bad_pad;
	logic [5:0]           v2;
	logic [5:0]           v3;
	logic [7:0]           b0;
	logic [7:0]           b1;
	logic [7:0]           b2;

	assign sym      = b64d_pkg::map_symbol(ch);
	assign skip     = failed_q || b64d_pkg::is_space(ch);
	assign complete = !eot && !skip && sym.ok && (cnt_q == 2'd3);
	assign bad_pad  = grp_q[0].pad || grp_q[1].pad;

	// padded symbols count as zero in the 24 bits
	assign v2 = grp_q[2].pad ? 6'd0 : grp_q[2].val;
	assign v3 = sym.pad ? 6'd0 : sym.val;
	assign b0 = {grp_q[0].val, grp_q[1].val[5:4]};
	assign b1 = {grp_q[1].val[3:0], v2[5:2]};
	assign b2 = {v2[1:0], v3};

	always_comb begin
		res = '0;
		res.kind = b64d_pkg::KIND_DATA;
		if (eot) begin
			res.cnt  = 2'd1;
			res.kind = (failed_q || (cnt_q != 2'd0)) ? b64d_pkg::KIND_FAIL
			                                         : b64d_pkg::KIND_OK;
		end else if (complete && !bad_pad) begin
			res.cnt      = 2'd1 + {1'b0, !grp_q[2].pad} + {1'b0, !sym.pad};
			res.bytes[0] = b0;
			// a padded third symbol drops the middle byte and closes the gap
			res.bytes[1] = grp_q[2].pad ? b2 : b1;
			res.bytes[2] = b2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			failed_q <= 1'b0;
			grp_q[0] <= '0;
			grp_q[1] <= '0;
			grp_q[2] <= '0;
		end else if (ena) begin
			if (eot) begin
				cnt_q    <= 2'd0;
				failed_q <= 1'b0;
			end else if (!skip) begin
				if (!sym.ok) begin
					failed_q <= 1'b1;
				end else if (complete) begin
					cnt_q <= 2'd0;
					if (bad_pad) begin
						failed_q <= 1'b1;
					end
				end else begin
					unique case (cnt_q)
						2'd0:    grp_q[0] <= sym;
						2'd1:    grp_q[1] <= sym;
						default: grp_q[2] <= sym;
					endcase
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== hdl/b64d_out_buf.sv =====
`timescale 1ns / 1ps

module b64d_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  b64d_pkg::res_t res,
	output logic           free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // out_byte
	output logic [1:0]     m_tuser,   // kind
	output logic           m_tlast
);

	logic [1:0]            rem_q;
	logic [2:0][7:0]       data_q;
	b64d_pkg::kind_t       kind_q;
	logic                  pop;

	assign m_tvalid = (rem_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign free     = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);
	assign m_tdata  = data_q[0];
	assign m_tuser  = kind_q;
	assign m_tlast  = (rem_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load && (res.cnt != 2'd0)) begin
			rem_q <= res.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && (res.cnt != 2'd0)) begin
			data_q <= res.bytes;
			kind_q <= res.kind;
		end else if (pop) begin
			// advance to the next byte of the set
			data_q <= {8'd0, data_q[2], data_q[1]};
		end
	end

endmodule

// ===== hdl/base64_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
// An accepted character beat is registered in the input stage, and once the result register
// is free its result set is loaded there. One character is taken per cycle while the result
// register is free; a completed group gives one to three bytes at one byte per cycle while
// m_tready is high; a group of two or three bytes holds the input until its last is taken.
// Reset (arst_n low) clears the group count, the failure flag and both valid stages
// at once; the block is ready for input as soon as reset is released.

module base64_stream_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_char
	input  logic       s_tuser,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // kind
	output logic       m_tlast
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eot_s1;
	logic              res_free;
	logic              adv_s1;
	b64d_pkg::res_t    res;

	assign adv_s1   = valid_s1 && res_free;
	assign s_tready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tuser;
		end
	end

	b64d_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.ena    (adv_s1),
		.ch     (char_s1),
		.eot    (eot_s1),
		.res    (res)
	);

	b64d_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv_s1),
		.res      (res),
		.free     (res_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== hdl/b64d_checker.sv =====
`timescale 1ns / 1ps

module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// input stalls only while results wait downstream
	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// a status beat stands alone as the last of its set
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != b64d_pkg::KIND_DATA)) |-> m_tlast)
		else $error("status beat without tlast");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != b64d_pkg::KIND_DATA)) |-> (m_tdata == 8'd0))
		else $error("status beat carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast)))
		else $error("stalled result beat changed");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== tb/base64_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module base64_stream_decoder_unit_tb;

	typedef struct packed {
		logic [7:0]      data;
		b64d_pkg::kind_t kind;
		logic            last;
	} beat_t;

	// One stimulus row: when typed is set, n beats are given here instead of predicted
	typedef struct packed {
		logic [7:0]      ch;
		logic            eot;
		logic            typed;
		logic [1:0]      n;
		logic [23:0]     bytes;
		b64d_pkg::kind_t kind;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	// decoder state as seen by the prediction
	logic [6:0] held_syms [3];
	logic [1:0] held_cnt;
	logic       text_failed;
	beat_t      step_out [3];
	int         step_n;

	beat_t      due_beats [$];
	int         errors;
	int         chars_sent;
	int         send_idle_pct;
	int         recv_idle_pct;

	row_t script [29] = '{
		'{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000, b64d_pkg::KIND_OK},   // empty text is fine
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"/",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{8'h09, 1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"/",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"/",   1'b0, 1'b1, 2'd3, 24'h03FFFF, b64d_pkg::KIND_DATA},
		'{"+",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"9",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"=",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"=",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		// padded third symbol, fourth still yields a byte
		'{"Z",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"a",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"=",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{8'hFF, 1'b1, 1'b1, 2'd1, 24'h000000, b64d_pkg::KIND_OK},
		// padding in second position
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"=",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000, b64d_pkg::KIND_FAIL},
		// padding in first position
		'{"=",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{"A",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000, b64d_pkg::KIND_FAIL},
		// invalid character
		'{8'hFF, 1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000, b64d_pkg::KIND_FAIL},
		// partial group at end of text
		'{"0",   1'b0, 1'b0, 2'd0, 24'h000000, b64d_pkg::KIND_DATA},
		'{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000, b64d_pkg::KIND_FAIL}
	};

	base64_stream_decoder_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] sym_char(input int v);
		if (v < 26) return 8'(65 + v);
		if (v < 52) return 8'(97 + v - 26);
		if (v < 62) return 8'(48 + v - 52);
		return (v == 62) ? 8'h2B : 8'h2F;
	endfunction

	// Append one beat to the expected queue
	function automatic void queue_beat(input beat_t b);
		due_beats = {due_beats, b};
	endfunction

	// Work out the beats one accepted character causes; fills step_out and step_n
	task automatic decode_char(input logic [7:0] ch, input logic eot);
		logic [6:0]  s;
		logic        bad;
		logic [23:0] bits;
		step_n = 0;
		bad = 1'b0;
		s = '0;
		if (eot) begin
			step_out[0] = '{8'h00, (text_failed || held_cnt != 2'd0) ? b64d_pkg::KIND_FAIL
			                                                        : b64d_pkg::KIND_OK, 1'b1};
			step_n = 1;
			held_cnt = 2'd0;
			text_failed = 1'b0;
			return;
		end
		if (text_failed) return;
		if ((ch >= 8'h09 && ch <= 8'h0D) || ch == 8'h20) return;
		if (ch >= "A" && ch <= "Z") s = {1'b0, 6'(ch - 8'd65)};
		else if (ch >= "a" && ch <= "z") s = {1'b0, 6'(ch - 8'd97 + 8'd26)};
		else if (ch >= "0" && ch <= "9") s = {1'b0, 6'(ch - 8'd48 + 8'd52)};
		else if (ch == "+") s = 7'd62;
		else if (ch == "/") s = 7'd63;
		else if (ch == "=") s = 7'h40;
		else bad = 1'b1;
		if (bad) begin
			text_failed = 1'b1;
			return;
		end
		if (held_cnt != 2'd3) begin
			held_syms[held_cnt] = s;
			held_cnt = held_cnt + 2'd1;
			return;
		end
		held_cnt = 2'd0;
		if (held_syms[0][6] || held_syms[1][6]) begin
			text_failed = 1'b1;
			return;
		end
		// padded symbols count as zero in the 24 bits
		bits = {held_syms[0][5:0], held_syms[1][5:0],
			held_syms[2][6] ? 6'd0 : held_syms[2][5:0], s[6] ? 6'd0 : s[5:0]};
		step_out[step_n++] = '{bits[23:16], b64d_pkg::KIND_DATA, held_syms[2][6] && s[6]};
		if (!held_syms[2][6]) step_out[step_n++] = '{bits[15:8], b64d_pkg::KIND_DATA, s[6]};
		if (!s[6]) step_out[step_n++] = '{bits[7:0], b64d_pkg::KIND_DATA, 1'b1};
	endtask

	task automatic send_item(input row_t r);
		int    i;
		beat_t b;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = r.ch;
		s_tuser  = r.eot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_sent++;
		decode_char(r.ch, r.eot);
		if (!r.typed) begin
			for (i = 0; i < step_n; i++) queue_beat(step_out[i]);
		end else if (r.kind == b64d_pkg::KIND_DATA) begin
			for (i = 0; i < r.n; i++) begin
				b = '{8'(r.bytes >> (16 - 8 * i)), b64d_pkg::KIND_DATA, i == r.n - 1};
				queue_beat(b);
			end
		end else begin
			b = '{8'h00, r.kind, 1'b1};
			queue_beat(b);
		end
	endtask

	// Random whitespace now and then ahead of a character
	task automatic send_char(input logic [7:0] c);
		int r;
		if ($urandom_range(0, 7) == 0) begin
			r = $urandom_range(0, 5);
			send_item('{(r == 5) ? 8'h20 : 8'(9 + r), 1'b0, 1'b0, 2'd0, 24'h0,
				b64d_pkg::KIND_DATA});
		end
		send_item('{c, 1'b0, 1'b0, 2'd0, 24'h0, b64d_pkg::KIND_DATA});
	endtask

	// Mostly well-formed text, some noise, broken padding and cut-short groups
	task automatic send_random_text();
		int         mode;
		int         groups;
		int         pads;
		int         bad_g;
		int         bad_p;
		int         g;
		int         p;
		logic [7:0] c;
		mode = $urandom_range(0, 9);
		if (mode == 7) begin
			repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
		end else begin
			groups = $urandom_range(0, 4);
			if (mode == 8 && groups == 0) groups = 1;
			pads  = $urandom_range(0, 2);
			bad_g = (mode == 8) ? $urandom_range(0, groups - 1) : -1;
			bad_p = $urandom_range(0, 3);
			for (g = 0; g < groups; g++) begin
				for (p = 0; p < 4; p++) begin
					if (g == bad_g && p == bad_p) c = "=";
					else if (g == groups - 1 && p >= 4 - pads) c = "=";
					else if ($urandom_range(0, 15) == 0) c = "=";
					else c = sym_char($urandom_range(0, 63));
					send_char(c);
				end
			end
			if (mode == 9) begin
				repeat ($urandom_range(1, 3)) send_char(sym_char($urandom_range(0, 63)));
			end
		end
		send_item('{8'($urandom_range(0, 255)), 1'b1, 1'b0, 2'd0, 24'h0, b64d_pkg::KIND_DATA});
	endtask

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat data %h kind %0d last %b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				e = due_beats.pop_front();
				if (m_tdata !== e.data) begin
					$display("%0t: byte expected %h actual %h", $time, e.data, m_tdata);
					errors++;
				end
				if (m_tuser !== e.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, e.kind, m_tuser);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		errors = 0;
		chars_sent = 0;
		held_syms[0] = '0;
		held_syms[1] = '0;
		held_syms[2] = '0;
		held_cnt = 2'd0;
		text_failed = 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 48;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < 29; i++) send_item(script[i]);

		while (chars_sent < 400) begin
			if (chars_sent >= 290) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (chars_sent >= 160) begin
				send_idle_pct = 48;
				recv_idle_pct = 12;
			end
			send_random_text();
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		// drain, then give any stray beat time to show up
		while (due_beats.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/b64d_pkg.sv
hdl/b64d_decode.sv
hdl/b64d_out_buf.sv
hdl/base64_stream_decoder_unit.sv
hdl/b64d_checker.sv
tb/base64_stream_decoder_unit_tb.sv
